/* rtl/core/bhmc_pkg.sv */
// Shared types and constants for the bilinear height map compensation block.
`timescale 1ns / 1ps
package bhmc_pkg;

  // Default grid dimension in points per axis.
  localparam int GRID_DIM_DEF = 64;

  // Widest cell index and point count that any grid dimension up to 2048 needs.
  localparam int CELL_W = 11;
  localparam int PTS_W  = 12;

  // Fixed field widths.
  localparam int ADDR_W = 12;
  localparam int DATA_W = 32;
  localparam int UNIT_W = 31;
  localparam int FRAC_W = 17;
  localparam int FACQ_W = 16;
  localparam int CFG_W  = 31;
  localparam int IDX_W  = 3;

  // Depth of the queue between the front and back parts.
  localparam int Q_DEPTH = 2;

  // One in Q1.16.
  localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_MAP_LOADED  = 3'd0,
    REG_X_ORIGIN    = 3'd1,
    REG_Y_ORIGIN    = 3'd2,
    REG_X_POINTS    = 3'd3,
    REG_Y_POINTS    = 3'd4,
    REG_OUTPUT_UNIT = 3'd5
  } reg_idx_t;

  // What a transaction asks of the back part.
  typedef enum logic [1:0] {
    CLS_WRITE = 2'd0,
    CLS_ZERO  = 2'd1,
    CLS_CALC  = 2'd2
  } cls_t;

  // How the fade factor is obtained.
  typedef enum logic [1:0] {
    FADE_FULL = 2'd0,
    FADE_NONE = 2'd1,
    FADE_DIV  = 2'd2
  } fade_t;

  // One classified transaction as it travels through the queue.
  typedef struct packed {
    cls_t                    cls;
    logic                    wr_ok;
    logic [ADDR_W-1:0]       wr_addr;
    logic [DATA_W-1:0]       wr_data;
    logic [CELL_W-1:0]       ix;
    logic [CELL_W-1:0]       iy;
    logic [FRAC_W-1:0]       tx;
    logic [FRAC_W-1:0]       ty;
    logic [PTS_W-1:0]        xp;
    fade_t                   fmode;
    logic [UNIT_W-1:0]       fnum;
    logic [UNIT_W-1:0]       fden;
  } item_t;

endpackage

/* rtl/core/bhmc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with a carried tag.
`timescale 1ns / 1ps
module bhmc_div #(
  parameter int DW = 31,
  parameter int QW = 16,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [DW-1:0] rem0,
  input  logic [QW-1:0] word,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [TW-1:0] out_tag
);

  logic          vld [QW+1];
  logic [DW-1:0] rem [QW+1];
  logic [QW-1:0] wrd [QW+1];
  logic [QW-1:0] qq  [QW+1];
  logic [DW-1:0] dd  [QW+1];
  logic [TW-1:0] tg  [QW+1];

  // Stage zero is the input itself.
  assign vld[0] = in_valid;
  assign rem[0] = rem0;
  assign wrd[0] = word;
  assign qq[0]  = '0;
  assign dd[0]  = den;
  assign tg[0]  = tag;

  genvar k;
  generate
    for (k = 0; k < QW; k++) begin : g_stage
      logic [DW:0] trial;
      logic        ge;

      // Shift in the next dividend bit and try a subtraction.
      assign trial = {rem[k], wrd[k][QW-1]};
      assign ge    = trial >= {1'b0, dd[k]};

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k+1] <= 1'b0;
        end else begin
          vld[k+1] <= vld[k];
        end
      end

      always_ff @(posedge clk) begin
        rem[k+1] <= ge ? DW'(trial - {1'b0, dd[k]}) : trial[DW-1:0];
        wrd[k+1] <= wrd[k] << 1;
        qq[k+1]  <= (qq[k] << 1) | QW'(ge);
        dd[k+1]  <= dd[k];
        tg[k+1]  <= tg[k];
      end
    end
  endgenerate

  assign out_valid = vld[QW];
  assign quo       = qq[QW];
  assign out_tag   = tg[QW];

endmodule

/* rtl/core/bhmc_front.sv */
// Front part: accepts transactions, locates the grid cell and classifies the fade.
`timescale 1ns / 1ps
module bhmc_front #(
  parameter int GRID_DIM = bhmc_pkg::GRID_DIM_DEF
) (
  input  logic                          start,
  input  logic                          busy,
  input  logic                          action,
  input  logic [bhmc_pkg::ADDR_W-1:0]   grid_address,
  input  logic signed [31:0]            grid_value,
  input  logic                          enable,
  input  logic                          clear,
  input  logic signed [31:0]            x_position,
  input  logic signed [31:0]            y_position,
  input  logic signed [31:0]            z_position,
  input  logic signed [31:0]            fade_limit,
  input  logic                          map_loaded,
  input  logic signed [15:0]            grid_x_origin,
  input  logic signed [15:0]            grid_y_origin,
  input  logic [6:0]                    grid_x_points,
  input  logic [6:0]                    grid_y_points,
  output logic                          push,
  output bhmc_pkg::item_t               item
);
  import bhmc_pkg::*;

  typedef struct packed {
    logic [CELL_W-1:0] cidx;
    logic [FRAC_W-1:0] frac;
  } loc_t;

  // Clamp the number of points in use to the grid.
  function automatic logic [PTS_W-1:0] clamp_pts(input logic [6:0] p);
    logic [PTS_W-1:0] r;
    if (p < 7'd2) begin
      r = PTS_W'(2);
    end else if (32'(p) > 32'(GRID_DIM)) begin
      r = PTS_W'(GRID_DIM);
    end else begin
      r = PTS_W'(p);
    end
    return r;
  endfunction

  // Clamp a position to one axis and split it into cell index and fraction.
  function automatic loc_t locate(input logic signed [31:0] pos,
                                  input logic signed [15:0] org,
                                  input logic [PTS_W-1:0]   pts);
    logic signed [33:0] lo;
    logic signed [33:0] hi;
    logic signed [33:0] p;
    logic signed [33:0] g;
    logic signed [17:0] hi_mm;
    logic [17:0]        craw;
    logic [17:0]        cmax;
    loc_t               r;
    lo    = {{2{org[15]}}, org, 16'h0000};
    hi_mm = 18'(org) + 18'(signed'({1'b0, pts})) - 18'sd1;
    hi    = {hi_mm, 16'h0000};
    p     = 34'(pos);
    if (p < lo) p = lo;
    if (p > hi) p = hi;
    g     = p - lo;
    craw  = g[33:16];
    cmax  = 18'(pts) - 18'd2;
    if (craw > cmax) begin
      // Only the far edge lands here, so the fraction is exactly one.
      r.cidx = CELL_W'(cmax);
      r.frac = ONE_Q16;
    end else begin
      r.cidx = CELL_W'(craw);
      r.frac = {1'b0, g[15:0]};
    end
    return r;
  endfunction

  logic [PTS_W-1:0] xp;
  logic [PTS_W-1:0] yp;
  loc_t             lx;
  loc_t             ly;
  logic [31:0]      fade_diff;

  assign push      = start && !busy;
  assign xp        = clamp_pts(grid_x_points);
  assign yp        = clamp_pts(grid_y_points);
  assign lx        = locate(x_position, grid_x_origin, xp);
  assign ly        = locate(y_position, grid_y_origin, yp);
  assign fade_diff = 32'(fade_limit - z_position);

  // Build the transaction for the back part.
  always_comb begin
    item         = '0;
    item.wr_ok   = 32'(grid_address) < 32'(GRID_DIM * GRID_DIM);
    item.wr_addr = grid_address;
    item.wr_data = grid_value;
    item.ix      = lx.cidx;
    item.iy      = ly.cidx;
    item.tx      = lx.frac;
    item.ty      = ly.frac;
    item.xp      = xp;
    item.fnum    = '0;
    item.fden    = UNIT_W'(1);
    if (!action) begin
      item.cls = CLS_WRITE;
    end else if (enable && map_loaded && !clear) begin
      item.cls = CLS_CALC;
    end else begin
      item.cls = CLS_ZERO;
    end
    if (fade_limit <= 0) begin
      item.fmode = FADE_FULL;
    end else if (z_position >= fade_limit) begin
      item.fmode = FADE_NONE;
    end else if (z_position <= 0) begin
      item.fmode = FADE_FULL;
    end else begin
      item.fmode = FADE_DIV;
      item.fnum  = fade_diff[UNIT_W-1:0];
      item.fden  = fade_limit[UNIT_W-1:0];
    end
  end

endmodule

/* rtl/core/bhmc_queue.sv */
// Short queue that decouples the front part from the back part.
`timescale 1ns / 1ps
module bhmc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bhmc_pkg::item_t din,
  input  logic            pop,
  output bhmc_pkg::item_t dout,
  output logic            full,
  output logic            empty
);
  import bhmc_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  item_t            slots [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(Q_DEPTH);
  assign empty = count == '0;
  assign dout  = slots[rd_ptr];

  // Pointer and occupancy tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not rise on a lone push");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (pop && !push && !empty) |=> count == $past(count) - 1'b1)
    else $error("queue count did not fall on a lone pop");
`endif

endmodule

/* rtl/core/bhmc_back.sv */
// Back part: fade division, grid storage, bilinear interpolation and unit scaling.
`timescale 1ns / 1ps
module bhmc_back #(
  parameter int GRID_DIM = bhmc_pkg::GRID_DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  bhmc_pkg::item_t               item,
  input  logic [bhmc_pkg::UNIT_W-1:0]   unit,
  output logic                          done,
  output logic signed [31:0]            counts
);
  import bhmc_pkg::*;

  localparam int DEPTH = GRID_DIM * GRID_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $bits(item_t);

  // Fade factor division, carrying the whole transaction alongside.
  logic              fv;
  logic [FACQ_W-1:0] fq;
  logic [TW-1:0]     ftag;
  item_t             fit;

  bhmc_div #(.DW(UNIT_W), .QW(FACQ_W), .TW(TW)) u_fade_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .rem0     (item.fnum),
    .word     ('0),
    .den      (item.fden),
    .tag      (TW'(item)),
    .out_valid(fv),
    .quo      (fq),
    .out_tag  (ftag)
  );

  assign fit = item_t'(ftag);

  // Stage 0: corner addresses.
  logic              v0;
  cls_t              cls0;
  logic              wr_ok0;
  logic [AW-1:0]     wr_addr0;
  logic [DATA_W-1:0] wr_data0;
  logic [AW-1:0]     a00;
  logic [AW-1:0]     a01;
  logic [AW-1:0]     a10;
  logic [AW-1:0]     a11;
  logic [FRAC_W-1:0] tx0;
  logic [FRAC_W-1:0] ty0;
  fade_t             fmode0;
  logic [FACQ_W-1:0] fq0;
  logic [AW-1:0]     base;

  assign base = AW'(AW'(fit.iy) * AW'(fit.xp)) + AW'(fit.ix);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= fv;
    end
  end

  always_ff @(posedge clk) begin
    cls0     <= fit.cls;
    wr_ok0   <= fit.wr_ok;
    wr_addr0 <= AW'(fit.wr_addr);
    wr_data0 <= fit.wr_data;
    a00      <= base;
    a01      <= base + 1'b1;
    a10      <= base + AW'(fit.xp);
    a11      <= base + AW'(fit.xp) + 1'b1;
    tx0      <= fit.tx;
    ty0      <= fit.ty;
    fmode0   <= fit.fmode;
    fq0      <= fq;
  end

  // Stage 1: two copies of the grid, each with two read ports, one per cell row.
  logic [DATA_W-1:0] mem_lo [DEPTH];
  logic [DATA_W-1:0] mem_hi [DEPTH];
  logic              v1;
  cls_t              cls1;
  logic signed [31:0] h00;
  logic signed [31:0] h01;
  logic signed [31:0] h10;
  logic signed [31:0] h11;
  logic [FRAC_W-1:0] tx1;
  logic [FRAC_W-1:0] ty1;
  fade_t             fmode1;
  logic [FACQ_W-1:0] fq1;

  always_ff @(posedge clk) begin
    if (v0 && cls0 == CLS_WRITE && wr_ok0) begin
      mem_lo[wr_addr0] <= wr_data0;
      mem_hi[wr_addr0] <= wr_data0;
    end
    h00 <= mem_lo[a00];
    h01 <= mem_lo[a01];
    h10 <= mem_hi[a10];
    h11 <= mem_hi[a11];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    cls1   <= cls0;
    tx1    <= tx0;
    ty1    <= ty0;
    fmode1 <= fmode0;
    fq1    <= fq0;
  end

  // Stage 2: interpolate along X in each row and settle the fade factor.
  logic signed [17:0] wx0;
  logic signed [17:0] wx1;
  logic               v2;
  cls_t               cls2;
  logic signed [49:0] row0;
  logic signed [49:0] row1;
  logic [FRAC_W-1:0]  ty2;
  logic [FRAC_W-1:0]  fac2;

  assign wx0 = signed'({1'b0, ONE_Q16 - tx1});
  assign wx1 = signed'({1'b0, tx1});

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    cls2 <= cls1;
    row0 <= 50'(h00) * 50'(wx0) + 50'(h01) * 50'(wx1);
    row1 <= 50'(h10) * 50'(wx0) + 50'(h11) * 50'(wx1);
    ty2  <= ty1;
    case (fmode1)
      FADE_FULL: fac2 <= ONE_Q16;
      FADE_NONE: fac2 <= '0;
      FADE_DIV:  fac2 <= {1'b0, fq1};
      default:   fac2 <= ONE_Q16;
    endcase
  end

  // Stage 3: interpolate along Y and round down to a Q16.16 height.
  logic signed [17:0] wy0;
  logic signed [17:0] wy1;
  logic signed [67:0] hsum;
  logic               v3;
  cls_t               cls3;
  logic signed [31:0] zoff;
  logic [FRAC_W-1:0]  fac3;

  assign wy0  = signed'({1'b0, ONE_Q16 - ty2});
  assign wy1  = signed'({1'b0, ty2});
  assign hsum = 68'(row0) * 68'(wy0) + 68'(row1) * 68'(wy1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    cls3 <= cls2;
    zoff <= hsum[63:32];
    fac3 <= fac2;
  end

  // Stage 4: apply the fade factor.
  logic signed [17:0] fac_s;
  logic               v4;
  cls_t               cls4;
  logic signed [48:0] val;

  assign fac_s = signed'({1'b0, fac3});

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    cls4 <= cls3;
    val  <= 49'(zoff) * 49'(fac_s);
  end

  // Divide the magnitude by the output unit; the Q16 scale drops out as a shift.
  logic        neg;
  logic [48:0] mag;
  logic [31:0] mnum;
  logic [2:0]  utag;
  logic        uv;
  logic [31:0] uq;
  logic [2:0]  utag_o;

  assign neg  = val < 0;
  assign mag  = neg ? 49'(-val) : 49'(val);
  assign mnum = mag[47:16];
  assign utag = {cls4 != CLS_WRITE, cls4 == CLS_ZERO, neg};

  bhmc_div #(.DW(UNIT_W), .QW(32), .TW(3)) u_unit_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v4),
    .rem0     ('0),
    .word     (mnum),
    .den      (unit),
    .tag      (utag),
    .out_valid(uv),
    .quo      (uq),
    .out_tag  (utag_o)
  );

  // Result register: sign, saturation and forced zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= uv && utag_o[2];
    end
  end

  always_ff @(posedge clk) begin
    if (utag_o[1]) begin
      counts <= '0;
    end else if (utag_o[0]) begin
      counts <= signed'(32'(-uq));
    end else if (uq[31]) begin
      counts <= 32'sh7FFF_FFFF;
    end else begin
      counts <= signed'(uq);
    end
  end

endmodule

/* rtl/core/bilinear_height_map_compensation.sv */
// Top level: configuration registers, front part, queue and back part.
// Throughput: one transaction per cycle, set by the fully pipelined dividers
// (16 stages for the fade factor, 32 for the output unit).
// Reset loads the configuration defaults and clears all valid state; grid data
// is undefined until written. The receiver cannot stall, so busy stays low.
`timescale 1ns / 1ps
module bilinear_height_map_compensation #(
  parameter int GRID_DIM = bhmc_pkg::GRID_DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_write,
  input  logic [bhmc_pkg::IDX_W-1:0]    cfg_index,
  input  logic [bhmc_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          action,
  input  logic [bhmc_pkg::ADDR_W-1:0]   grid_address,
  input  logic signed [31:0]            grid_value,
  input  logic                          enable,
  input  logic                          clear,
  input  logic signed [31:0]            x_position,
  input  logic signed [31:0]            y_position,
  input  logic signed [31:0]            z_position,
  input  logic signed [31:0]            fade_limit,
  output logic                          done,
  output logic signed [31:0]            counts,
  output logic [bhmc_pkg::UNIT_W-1:0]   scale_out
);
  import bhmc_pkg::*;

  logic               map_loaded;
  logic signed [15:0] grid_x_origin;
  logic signed [15:0] grid_y_origin;
  logic [6:0]         grid_x_points;
  logic [6:0]         grid_y_points;
  logic [UNIT_W-1:0]  output_unit;
  logic [UNIT_W-1:0]  unit_eff;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      map_loaded    <= 1'b0;
      grid_x_origin <= '0;
      grid_y_origin <= '0;
      grid_x_points <= 7'd2;
      grid_y_points <= 7'd2;
      output_unit   <= UNIT_W'(66);
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_MAP_LOADED:  map_loaded    <= cfg_data[0];
        REG_X_ORIGIN:    grid_x_origin <= signed'(cfg_data[15:0]);
        REG_Y_ORIGIN:    grid_y_origin <= signed'(cfg_data[15:0]);
        REG_X_POINTS:    grid_x_points <= cfg_data[6:0];
        REG_Y_POINTS:    grid_y_points <= cfg_data[6:0];
        REG_OUTPUT_UNIT: output_unit   <= cfg_data;
        default: ;
      endcase
    end
  end

  // A zero unit divides as one; the echo keeps the raw value.
  assign unit_eff  = (output_unit == '0) ? UNIT_W'(1) : output_unit;
  assign scale_out = output_unit;

  logic  push;
  logic  empty;
  item_t fitem;
  item_t qitem;

  bhmc_front #(.GRID_DIM(GRID_DIM)) u_front (
    .start        (start),
    .busy         (busy),
    .action       (action),
    .grid_address (grid_address),
    .grid_value   (grid_value),
    .enable       (enable),
    .clear        (clear),
    .x_position   (x_position),
    .y_position   (y_position),
    .z_position   (z_position),
    .fade_limit   (fade_limit),
    .map_loaded   (map_loaded),
    .grid_x_origin(grid_x_origin),
    .grid_y_origin(grid_y_origin),
    .grid_x_points(grid_x_points),
    .grid_y_points(grid_y_points),
    .push         (push),
    .item         (fitem)
  );

  bhmc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (fitem),
    .pop  (!empty),
    .dout (qitem),
    .full (busy),
    .empty(empty)
  );

  bhmc_back #(.GRID_DIM(GRID_DIM)) u_back (
    .clk     (clk),
    .rst     (rst),
    .in_valid(!empty),
    .item    (qitem),
    .unit    (unit_eff),
    .done    (done),
    .counts  (counts)
  );

endmodule
